@@ hw/rtl/rrtc_pkg.sv @@
// Shared types, codes and constants for the reserved range table checker.
package rrtc_pkg;

   // Default sizing of the zone table and the block address space
   localparam int MAX_ZONES_DEF  = 64;
   localparam int BLOCK_BITS_DEF = 48;

   // Fixed field widths
   localparam int COUNT_W = 32;
   localparam int OWNER_W = 32;
   localparam int FDB_W   = 32;
   localparam int TOTAL_W = 48;

   // Configuration port
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int REG_SEL_LSB = 3;

   typedef logic [CSR_ADDR_W-REG_SEL_LSB-1:0] reg_index_type;
   localparam reg_index_type REG_FIRST_DATA_BLOCK = 1'b0;
   localparam reg_index_type REG_TOTAL_BLOCKS     = 1'b1;

   // Request codes
   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_INSERT = 2'd0;
   localparam req_code_type REQ_CHECK  = 2'd1;
   localparam req_code_type REQ_CLEAR  = 2'd2;

   // Insert status codes
   typedef logic [1:0] status_type;
   localparam status_type STS_OK      = 2'd0;
   localparam status_type STS_OVERLAP = 2'd1;
   localparam status_type STS_FULL    = 2'd2;

   // Control sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COMMIT
   } state_type;

   // How the cell row changes on a committed insert
   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_SHIFT_IN,
      MODE_GROW_PREV,
      MODE_JOIN_BOTH,
      MODE_JOIN_NEXT
   } mode_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic     eval;
      logic     commit;
      mode_type mode;
   } cell_cmd_type;

   // Per-cell result of the compare pass, registered in the cell
   typedef struct packed {
      logic hit;
      logic bad_owner;
      logic cand_grow;
      logic cand_both;
      logic cand_next;
   } cell_flags_type;

endpackage

@@ hw/rtl/rrtc_csr.sv @@
// Configuration registers behind the APB-style port.
module rrtc_csr import rrtc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [FDB_W-1:0]      first_data_block,
   output logic [TOTAL_W-1:0]    total_blocks
);

   logic [FDB_W-1:0]   first_data_block_ff, first_data_block_in;
   logic [TOTAL_W-1:0] total_blocks_ff, total_blocks_in;
   reg_index_type      reg_index;
   logic               wr_transfer;

   assign pready      = 1'b1;
   assign reg_index   = paddr[CSR_ADDR_W-1:REG_SEL_LSB];
   assign wr_transfer = psel && penable && pwrite;

   // Write decode
   always_comb begin
      first_data_block_in = first_data_block_ff;
      total_blocks_in     = total_blocks_ff;
      if (wr_transfer) begin
         case (reg_index)
            REG_FIRST_DATA_BLOCK: first_data_block_in = pwdata[FDB_W-1:0];
            REG_TOTAL_BLOCKS:     total_blocks_in     = pwdata[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_data_block_ff <= '0;
         total_blocks_ff     <= '0;
      end else begin
         first_data_block_ff <= first_data_block_in;
         total_blocks_ff     <= total_blocks_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_index)
         REG_FIRST_DATA_BLOCK: prdata = CSR_DATA_W'(first_data_block_ff);
         REG_TOTAL_BLOCKS:     prdata = CSR_DATA_W'(total_blocks_ff);
         default:              prdata = '0;
      endcase
   end

   assign first_data_block = first_data_block_ff;
   assign total_blocks     = total_blocks_ff;

endmodule

@@ hw/rtl/rrtc_cell.sv @@
// One zone cell of the sorted range row: compare against the request, then shift or merge.
module rrtc_cell import rrtc_pkg::*; #(
   parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
   input  logic                  clock,
   input  cell_cmd_type          cmd,
   input  logic                  occupied,
   // request broadcast
   input  logic [BLOCK_BITS-1:0] req_start,
   input  logic [BLOCK_BITS:0]   req_end,
   input  logic [COUNT_W-1:0]    req_count,
   input  logic [OWNER_W-1:0]    req_owner,
   input  logic                  req_has_owner,
   // lower neighbor
   input  logic [BLOCK_BITS-1:0] prev_start,
   input  logic [COUNT_W-1:0]    prev_length,
   input  logic [OWNER_W-1:0]    prev_owner,
   input  logic                  prev_less,
   // upper neighbor
   input  logic [BLOCK_BITS-1:0] next_start,
   input  logic [COUNT_W-1:0]    next_length,
   input  logic [OWNER_W-1:0]    next_owner,
   input  logic                  next_less,
   input  logic                  next_adj_after,
   // to neighbors and controller
   output logic [BLOCK_BITS-1:0] zone_start,
   output logic [COUNT_W-1:0]    zone_length,
   output logic [OWNER_W-1:0]    zone_owner,
   output logic                  less_now,
   output logic                  adj_after_now,
   output cell_flags_type        flags
);

   logic [BLOCK_BITS-1:0] start_ff, start_in;
   logic [COUNT_W-1:0]    length_ff, length_in;
   logic [OWNER_W-1:0]    owner_ff, owner_in;

   cell_flags_type        flags_ff, flags_in;
   logic                  less_ff, is_p_ff, is_prev_ff;
   logic [COUNT_W-1:0]    sum_ff, tot_ff;

   logic [BLOCK_BITS:0]   zone_end;
   logic [COUNT_W:0]      sum;
   logic [COUNT_W+1:0]    tot;
   logic                  hit, owner_eq, adj_before, is_p, is_prev, tot_ok;

   // Compare pass
   always_comb begin
      zone_end      = {1'b0, start_ff} + (BLOCK_BITS+1)'(length_ff);
      owner_eq      = owner_ff == req_owner;
      sum           = {1'b0, length_ff} + {1'b0, req_count};
      tot           = {2'b00, length_ff} + {2'b00, req_count} + {2'b00, next_length};
      tot_ok        = tot[COUNT_W+1:COUNT_W] == 2'b00;
      less_now      = occupied && (start_ff < req_start);
      hit           = occupied && ({1'b0, start_ff} < req_end) &&
                      ({1'b0, req_start} < zone_end);
      adj_before    = occupied && (zone_end == {1'b0, req_start}) && owner_eq && !sum[COUNT_W];
      adj_after_now = occupied && (req_end == {1'b0, start_ff}) && owner_eq && !sum[COUNT_W];
      // insertion point is the first cell not below the new start
      is_p          = !less_now && prev_less;
      is_prev       = less_now && !next_less;

      flags_in.hit       = hit;
      flags_in.bad_owner = hit && (!req_has_owner || !owner_eq);
      flags_in.cand_grow = is_prev && adj_before;
      flags_in.cand_both = is_prev && adj_before && next_adj_after && tot_ok;
      flags_in.cand_next = is_p && adj_after_now;
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         flags_ff   <= flags_in;
         less_ff    <= less_now;
         is_p_ff    <= is_p;
         is_prev_ff <= is_prev;
         sum_ff     <= sum[COUNT_W-1:0];
         tot_ff     <= tot[COUNT_W-1:0];
      end
   end

   // Entry update on commit
   always_comb begin
      start_in  = start_ff;
      length_in = length_ff;
      owner_in  = owner_ff;
      if (cmd.commit) begin
         case (cmd.mode)
            MODE_SHIFT_IN: begin
               if (is_p_ff) begin
                  start_in  = req_start;
                  length_in = req_count;
                  owner_in  = req_owner;
               end else if (!less_ff) begin
                  start_in  = prev_start;
                  length_in = prev_length;
                  owner_in  = prev_owner;
               end
            end
            MODE_GROW_PREV: begin
               if (is_prev_ff) begin
                  length_in = sum_ff;
               end
            end
            MODE_JOIN_BOTH: begin
               if (is_prev_ff) begin
                  length_in = tot_ff;
               end else if (!less_ff) begin
                  start_in  = next_start;
                  length_in = next_length;
                  owner_in  = next_owner;
               end
            end
            MODE_JOIN_NEXT: begin
               if (is_p_ff) begin
                  start_in  = req_start;
                  length_in = sum_ff;
                  owner_in  = req_owner;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      length_ff <= length_in;
      owner_ff  <= owner_in;
   end

   assign zone_start  = start_ff;
   assign zone_length = length_ff;
   assign zone_owner  = owner_ff;
   assign flags       = flags_ff;

endmodule

@@ hw/rtl/reserved_range_table_checker_core.sv @@
// Reserved range table checker: control sequencer, request registers and the zone cell row.
//
// Keeps up to MAX_ZONES sorted, non-overlapping reserved block ranges with owners.
// Request channel (req_*): valid/stall; a transfer carries an insert, check or
// clear request. Result channel (rsp_*): one result transfer per request, with
// rsp_range_valid for checks and rsp_status for inserts (both 0 otherwise).
// Every zone sits in a cell of the row; all cells compare against the request
// in parallel, then the row shifts or merges in one pass.
// Timing: a transferred request is compared in ST_EVAL, and its result is
// registered at the commit out of ST_COMMIT. Requests are taken one at a time;
// the next request is taken at the commit edge.
// If the receiver stalls, the result waits in the output register and the
// commit is held (req_stall high) until the output register frees up.
// Reset clears the zone count (empty table), the configuration registers
// and the handshake state; no clearing pass is needed.
// Configuration (APB-style, 64-bit data): first_data_block at 0x0,
// total_blocks at 0x8; write only while no request is in flight.
module reserved_range_table_checker_core import rrtc_pkg::*; #(
   parameter int MAX_ZONES  = MAX_ZONES_DEF,
   parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [BLOCK_BITS-1:0] req_start_block,
   input  logic [COUNT_W-1:0]    req_block_count,
   input  logic [OWNER_W-1:0]    req_owner_id,
   input  logic                  req_has_owner,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_range_valid,
   output logic [1:0]            rsp_status,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int USED_W = $clog2(MAX_ZONES + 1);
   localparam int CMP_W  = (BLOCK_BITS + 1 > TOTAL_W) ? BLOCK_BITS + 1 : TOTAL_W;

   // Configuration
   logic [FDB_W-1:0]   first_data_block;
   logic [TOTAL_W-1:0] total_blocks;

   rrtc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .first_data_block (first_data_block),
      .total_blocks     (total_blocks)
   );

   // Control and request registers
   state_type             state_ff, state_in;
   logic [USED_W-1:0]     used_ff, used_in;
   req_code_type          type_ff;
   logic [BLOCK_BITS-1:0] start_ff;
   logic [BLOCK_BITS:0]   end_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [OWNER_W-1:0]    owner_ff;
   logic                  has_owner_ff;
   logic                  zero_count_ff, past_space_ff, out_of_bounds_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_range_valid_ff, rsp_range_valid_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  req_transfer, out_free, do_commit, do_eval;
   cell_cmd_type          cmd;
   mode_type              mode;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_transfer = req_valid && !req_stall;

   // Cell row
   logic [BLOCK_BITS-1:0] zs_arr [MAX_ZONES];
   logic [COUNT_W-1:0]    zl_arr [MAX_ZONES];
   logic [OWNER_W-1:0]    zo_arr [MAX_ZONES];
   logic [MAX_ZONES-1:0]  less_vec, adj_after_vec, occ_vec;
   logic [MAX_ZONES-1:0]  hit_vec, bad_vec, grow_vec, both_vec, next_vec;
   cell_flags_type        flags_arr [MAX_ZONES];

   for (genvar i = 0; i < MAX_ZONES; i++) begin : g_cell
      logic [BLOCK_BITS-1:0] p_start, n_start;
      logic [COUNT_W-1:0]    p_length, n_length;
      logic [OWNER_W-1:0]    p_owner, n_owner;
      logic                  p_less, n_less, n_adj_after;

      if (i == 0) begin : g_first
         assign p_start  = '0;
         assign p_length = '0;
         assign p_owner  = '0;
         assign p_less   = 1'b1;
      end else begin : g_mid_lo
         assign p_start  = zs_arr[i-1];
         assign p_length = zl_arr[i-1];
         assign p_owner  = zo_arr[i-1];
         assign p_less   = less_vec[i-1];
      end

      if (i == MAX_ZONES - 1) begin : g_last
         assign n_start     = '0;
         assign n_length    = '0;
         assign n_owner     = '0;
         assign n_less      = 1'b0;
         assign n_adj_after = 1'b0;
      end else begin : g_mid_hi
         assign n_start     = zs_arr[i+1];
         assign n_length    = zl_arr[i+1];
         assign n_owner     = zo_arr[i+1];
         assign n_less      = less_vec[i+1];
         assign n_adj_after = adj_after_vec[i+1];
      end

      assign occ_vec[i] = used_ff > USED_W'(i);

      rrtc_cell #(.BLOCK_BITS(BLOCK_BITS)) u_cell (
         .clock          (clock),
         .cmd            (cmd),
         .occupied       (occ_vec[i]),
         .req_start      (start_ff),
         .req_end        (end_ff),
         .req_count      (count_ff),
         .req_owner      (owner_ff),
         .req_has_owner  (has_owner_ff),
         .prev_start     (p_start),
         .prev_length    (p_length),
         .prev_owner     (p_owner),
         .prev_less      (p_less),
         .next_start     (n_start),
         .next_length    (n_length),
         .next_owner     (n_owner),
         .next_less      (n_less),
         .next_adj_after (n_adj_after),
         .zone_start     (zs_arr[i]),
         .zone_length    (zl_arr[i]),
         .zone_owner     (zo_arr[i]),
         .less_now       (less_vec[i]),
         .adj_after_now  (adj_after_vec[i]),
         .flags          (flags_arr[i])
      );

      assign hit_vec[i]  = flags_arr[i].hit;
      assign bad_vec[i]  = flags_arr[i].bad_owner;
      assign grow_vec[i] = flags_arr[i].cand_grow;
      assign both_vec[i] = flags_arr[i].cand_both;
      assign next_vec[i] = flags_arr[i].cand_next;
   end

   // Sequencer: next state and handshake
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      do_commit = 1'b0;
      do_eval   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            do_eval  = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            req_stall = !out_free;
            if (out_free) begin
               do_commit = 1'b1;
               state_in  = req_valid ? ST_EVAL : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Request registers; end block is precomputed at the transfer
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         type_ff      <= req_type;
         start_ff     <= req_start_block;
         end_ff       <= {1'b0, req_start_block} + (BLOCK_BITS+1)'(req_block_count);
         count_ff     <= req_block_count;
         owner_ff     <= req_owner_id;
         has_owner_ff <= req_has_owner;
      end
   end

   // Bounds tests during the compare cycle
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         zero_count_ff    <= count_ff == '0;
         past_space_ff    <= end_ff[BLOCK_BITS] && (end_ff[BLOCK_BITS-1:0] != '0);
         out_of_bounds_ff <= (start_ff <= BLOCK_BITS'(first_data_block)) ||
                             (CMP_W'(end_ff) > CMP_W'(total_blocks));
      end
   end

   // Commit decision and result
   always_comb begin
      mode               = MODE_NONE;
      used_in            = used_ff;
      rsp_range_valid_in = 1'b0;
      rsp_status_in      = STS_OK;
      case (type_ff)
         REQ_INSERT: begin
            if (zero_count_ff) begin
               rsp_status_in = STS_OK;
            end else if (past_space_ff || (|hit_vec)) begin
               rsp_status_in = STS_OVERLAP;
            end else if (used_ff == USED_W'(MAX_ZONES)) begin
               rsp_status_in = STS_FULL;
            end else if (|grow_vec) begin
               if (|both_vec) begin
                  mode    = MODE_JOIN_BOTH;
                  used_in = used_ff - USED_W'(1);
               end else begin
                  mode = MODE_GROW_PREV;
               end
            end else if (|next_vec) begin
               mode = MODE_JOIN_NEXT;
            end else begin
               mode    = MODE_SHIFT_IN;
               used_in = used_ff + USED_W'(1);
            end
         end
         REQ_CHECK: begin
            rsp_range_valid_in = !zero_count_ff && !past_space_ff &&
                                 !out_of_bounds_ff && !(|bad_vec);
         end
         REQ_CLEAR: used_in = '0;
         default: ;
      endcase
   end

   assign cmd = '{eval: do_eval, commit: do_commit, mode: mode};

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (do_commit) begin
         used_ff <= used_in;
      end
   end

   // Output register
   assign rsp_valid_in = do_commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_commit) begin
         rsp_range_valid_ff <= rsp_range_valid_in;
         rsp_status_ff      <= rsp_status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_valid = rsp_range_valid_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
